>>> src/bphc_pkg.sv
// ----------------------------------------------------------------------------
// bphc_pkg
// Shared types and constants for the button press / hold classifier.
// ----------------------------------------------------------------------------
package bphc_pkg;

	localparam int NUM_BUTTONS = 4;
	localparam int BTN_W       = $clog2(NUM_BUTTONS);
	localparam int COUNT_WIDTH = 32;
	localparam int THRESH_W    = 32;
	localparam int QTICKS_W    = 32;
	localparam int ACTION_W    = 3;
	localparam int REG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 32;

	localparam logic [COUNT_WIDTH-1:0] CNT_MAX    = {COUNT_WIDTH{1'b1}};
	localparam logic [THRESH_W-1:0]    THRESH_RST = THRESH_W'(100);

	typedef enum logic [ACTION_W-1:0] {
		ACT_TICK      = 3'd0,
		ACT_PIN       = 3'd1,
		ACT_PRESS_ACK = 3'd2,
		ACT_HOLD_ACK  = 3'd3,
		ACT_QUERY     = 3'd4
	} action_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_HOLD_THRESH = 2'd0,
		REG_HELD_EN     = 2'd1,
		REG_PRESS_EN    = 2'd2,
		REG_RELEASE_EN  = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [THRESH_W-1:0]    hold_thresh;
		logic [NUM_BUTTONS-1:0] held_en;
		logic [NUM_BUTTONS-1:0] press_en;
		logic [NUM_BUTTONS-1:0] release_en;
	} cfg_t;

	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic [BTN_W-1:0]    button;
		logic                pin_high;
		logic [QTICKS_W-1:0] query_ticks;
	} item_t;

	typedef struct packed {
		logic [NUM_BUTTONS-1:0] held_events;
		logic                   press_event;
		logic                   release_event;
		logic [BTN_W-1:0]       event_button;
		logic [NUM_BUTTONS-1:0] pressed_mask;
		logic [NUM_BUTTONS-1:0] short_press_mask;
		logic                   held_answer;
	} result_t;

endpackage

>>> src/bphc_cfg_regs.sv
// ----------------------------------------------------------------------------
// bphc_cfg_regs
// Configuration registers: hold threshold and per-button event enables.
// ----------------------------------------------------------------------------
module bphc_cfg_regs (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [bphc_pkg::REG_IDX_W-1:0]     cfg_index,
	input  logic [bphc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	output bphc_pkg::cfg_t                     cfg
);
	import bphc_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hold_thresh <= THRESH_RST;
			cfg_q.held_en     <= '0;
			cfg_q.press_en    <= '0;
			cfg_q.release_en  <= '0;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_HOLD_THRESH: cfg_q.hold_thresh <= cfg_wdata[THRESH_W-1:0];
				REG_HELD_EN:     cfg_q.held_en     <= cfg_wdata[NUM_BUTTONS-1:0];
				REG_PRESS_EN:    cfg_q.press_en    <= cfg_wdata[NUM_BUTTONS-1:0];
				REG_RELEASE_EN:  cfg_q.release_en  <= cfg_wdata[NUM_BUTTONS-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> src/bphc_btn_core.sv
// ----------------------------------------------------------------------------
// bphc_btn_core
// Per-button state (press counter, hold ack, short press pending) and the
// combinational update that turns one transaction into its result.
// ----------------------------------------------------------------------------
module bphc_btn_core (
	input  logic              clk,
	input  logic              arst_n,
	input  bphc_pkg::item_t   item,
	input  logic              advance,
	input  bphc_pkg::cfg_t    cfg,
	output bphc_pkg::result_t result_d
);
	import bphc_pkg::*;

	logic [COUNT_WIDTH-1:0] count_q [NUM_BUTTONS];
	logic [COUNT_WIDTH-1:0] count_d [NUM_BUTTONS];
	logic [NUM_BUTTONS-1:0] ack_q;
	logic [NUM_BUTTONS-1:0] ack_d;
	logic [NUM_BUTTONS-1:0] spp_q;
	logic [NUM_BUTTONS-1:0] spp_d;

	always_comb begin
		count_d  = count_q;
		ack_d    = ack_q;
		spp_d    = spp_q;
		result_d = '0;
		case (item.action)
			ACT_TICK: begin
				for (int i = 0; i < NUM_BUTTONS; i++) begin
					if (count_q[i] != '0 && count_q[i] != CNT_MAX) begin
						count_d[i] = count_q[i] + 1'b1;
						if (!ack_q[i] && cfg.held_en[i] && count_d[i] >= cfg.hold_thresh) begin
							ack_d[i]                = 1'b1;
							result_d.held_events[i] = 1'b1;
						end
					end
				end
			end
			ACT_PIN: begin
				result_d.event_button = item.button;
				if (item.pin_high) begin
					if (!ack_q[item.button]) begin
						spp_d[item.button] = 1'b1;
					end
					count_d[item.button]   = '0;
					ack_d[item.button]     = 1'b0;
					result_d.release_event = cfg.release_en[item.button];
				end else begin
					count_d[item.button] = COUNT_WIDTH'(1);
					result_d.press_event = cfg.press_en[item.button];
				end
			end
			ACT_PRESS_ACK: spp_d[item.button] = 1'b0;
			ACT_HOLD_ACK:  ack_d[item.button] = 1'b1;
			ACT_QUERY: begin
				result_d.held_answer = !ack_q[item.button] &&
					(count_q[item.button] >= item.query_ticks);
			end
			default: ;
		endcase
		for (int i = 0; i < NUM_BUTTONS; i++) begin
			result_d.pressed_mask[i] = (count_d[i] != '0);
		end
		result_d.short_press_mask = spp_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_BUTTONS; i++) begin
				count_q[i] <= '0;
			end
			ack_q <= '0;
			spp_q <= '0;
		end else if (advance) begin
			count_q <= count_d;
			ack_q   <= ack_d;
			spp_q   <= spp_d;
		end
	end

endmodule

>>> src/button_press_hold_classifier_core.sv
// ----------------------------------------------------------------------------
// button_press_hold_classifier_core
// Path: an accepted transaction passes the input register, then the result
// register; out_stall can hold it in the input register.
// Throughput: one transaction per cycle while out_stall does not hold the result.
// Reset: counters and flags clear, threshold 100, all event enables off.
// ----------------------------------------------------------------------------
module button_press_hold_classifier_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [bphc_pkg::REG_IDX_W-1:0]      cfg_index,
	input  logic [bphc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [bphc_pkg::ACTION_W-1:0]       action,
	input  logic [bphc_pkg::BTN_W-1:0]          button,
	input  logic                                pin_high,
	input  logic [bphc_pkg::QTICKS_W-1:0]       query_ticks,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [bphc_pkg::NUM_BUTTONS-1:0]    held_events,
	output logic                                press_event,
	output logic                                release_event,
	output logic [bphc_pkg::BTN_W-1:0]          event_button,
	output logic [bphc_pkg::NUM_BUTTONS-1:0]    pressed_mask,
	output logic [bphc_pkg::NUM_BUTTONS-1:0]    short_press_mask,
	output logic                                held_answer
);
	import bphc_pkg::*;

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	result_t result_d;
	result_t result_q;
	logic    out_valid_q;
	logic    advance;

	// s1 moves into the result register when that register is free or draining
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;

	bphc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	bphc_btn_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item_s1),
		.advance  (advance),
		.cfg      (cfg),
		.result_d (result_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1.action      <= action;
			item_s1.button      <= button;
			item_s1.pin_high    <= pin_high;
			item_s1.query_ticks <= query_ticks;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result_d;
		end
	end

	assign out_valid        = out_valid_q;
	assign held_events      = result_q.held_events;
	assign press_event      = result_q.press_event;
	assign release_event    = result_q.release_event;
	assign event_button     = result_q.event_button;
	assign pressed_mask     = result_q.pressed_mask;
	assign short_press_mask = result_q.short_press_mask;
	assign held_answer      = result_q.held_answer;

`ifndef SYNTH
	a_advance_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("result register not loaded after transaction advanced");

	a_press_release_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(press_event && release_event))
		else $error("press and release event in one transaction");

	a_answer_alone: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && held_answer) |-> (held_events == '0 && !press_event && !release_event))
		else $error("held answer together with events");

	a_press_sets_mask: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && press_event) |-> pressed_mask[event_button])
		else $error("press event without pressed button");

	a_release_clears_mask: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && release_event) |-> !pressed_mask[event_button])
		else $error("release event with button still pressed");
`endif

endmodule

>>> bench/tb_button_press_hold_classifier_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_button_press_hold_classifier_core
// Self-checking bench for the button press / hold classifier. A scoreboard
// object tracks per-button tick counts, hold and short-press flags and the
// event enables, predicts one result per accepted transaction and compares
// the results in order. Directed cases come first, then random phases under
// varied settings, with bursty input and a patterned output stall.
// ----------------------------------------------------------------------------
module tb_button_press_hold_classifier_core;
	import bphc_pkg::*;

	localparam int ACT_CODE_MAX = (1 << ACTION_W) - 1;
	localparam int NUM_PHASES   = 8;
	localparam int PHASE_ITEMS  = 190;

	class button_scoreboard;
		logic [COUNT_WIDTH-1:0] press_ticks[NUM_BUTTONS];
		bit                     hold_acked[NUM_BUTTONS];
		bit                     short_pending[NUM_BUTTONS];
		logic [THRESH_W-1:0]    hold_thresh;
		logic [NUM_BUTTONS-1:0] held_en;
		logic [NUM_BUTTONS-1:0] press_en;
		logic [NUM_BUTTONS-1:0] release_en;
		result_t                report_queue[$];
		int                     mismatch_count;

		function new();
			hold_thresh    = THRESH_RST;
			held_en        = '0;
			press_en       = '0;
			release_en     = '0;
			mismatch_count = 0;
			for (int i = 0; i < NUM_BUTTONS; i++) begin
				press_ticks[i]   = '0;
				hold_acked[i]    = 1'b0;
				short_pending[i] = 1'b0;
			end
		endfunction

		function void set_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				REG_HOLD_THRESH: hold_thresh = val[THRESH_W-1:0];
				REG_HELD_EN:     held_en     = val[NUM_BUTTONS-1:0];
				REG_PRESS_EN:    press_en    = val[NUM_BUTTONS-1:0];
				REG_RELEASE_EN:  release_en  = val[NUM_BUTTONS-1:0];
				default: ;
			endcase
		endfunction

		function result_t predict_report(item_t it);
			result_t          r;
			logic [BTN_W-1:0] b;
			r = '0;
			b = it.button;
			case (it.action)
				ACT_TICK: begin
					for (int i = 0; i < NUM_BUTTONS; i++) begin
						if (press_ticks[i] != '0 && press_ticks[i] != CNT_MAX) begin
							press_ticks[i] = press_ticks[i] + 1'b1;
							if (!hold_acked[i] && held_en[i] && press_ticks[i] >= hold_thresh) begin
								hold_acked[i]     = 1'b1;
								r.held_events[i] = 1'b1;
							end
						end
					end
				end
				ACT_PIN: begin
					r.event_button = it.button;
					if (it.pin_high) begin
						if (!hold_acked[b])
							short_pending[b] = 1'b1;
						press_ticks[b]  = '0;
						hold_acked[b]   = 1'b0;
						r.release_event = release_en[b];
					end else begin
						press_ticks[b] = COUNT_WIDTH'(1);
						r.press_event  = press_en[b];
					end
				end
				ACT_PRESS_ACK: short_pending[b] = 1'b0;
				ACT_HOLD_ACK:  hold_acked[b] = 1'b1;
				ACT_QUERY:     r.held_answer = !hold_acked[b] && press_ticks[b] >= it.query_ticks;
				default: ;
			endcase
			for (int i = 0; i < NUM_BUTTONS; i++) begin
				r.pressed_mask[i]     = press_ticks[i] != '0;
				r.short_press_mask[i] = short_pending[i];
			end
			return r;
		endfunction

		function void note_transaction(item_t it);
			report_queue.push_back(predict_report(it));
		endfunction

		function void compare_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
			if (exp_val !== act_val) begin
				$display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_val,
					act_val);
				mismatch_count++;
			end
		endfunction

		function void check_report(result_t got);
			result_t exp_r;
			if (report_queue.size() == 0) begin
				$display("%0t: unexpected result, expected none actual %0h", $time, got);
				mismatch_count++;
				return;
			end
			exp_r = report_queue.pop_front();
			compare_field("held_events", 32'(exp_r.held_events), 32'(got.held_events));
			compare_field("press_event", 32'(exp_r.press_event), 32'(got.press_event));
			compare_field("release_event", 32'(exp_r.release_event),
				32'(got.release_event));
			compare_field("event_button", 32'(exp_r.event_button), 32'(got.event_button));
			compare_field("pressed_mask", 32'(exp_r.pressed_mask), 32'(got.pressed_mask));
			compare_field("short_press_mask", 32'(exp_r.short_press_mask),
				32'(got.short_press_mask));
			compare_field("held_answer", 32'(exp_r.held_answer), 32'(got.held_answer));
		endfunction

		function int pending();
			return report_queue.size();
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   cfg_we;
	logic [REG_IDX_W-1:0]   cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_wdata;
	logic                   in_valid;
	logic                   in_stall;
	logic [ACTION_W-1:0]    action;
	logic [BTN_W-1:0]       button;
	logic                   pin_high;
	logic [QTICKS_W-1:0]    query_ticks;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	logic [NUM_BUTTONS-1:0] held_events;
	logic                   press_event;
	logic                   release_event;
	logic [BTN_W-1:0]       event_button;
	logic [NUM_BUTTONS-1:0] pressed_mask;
	logic [NUM_BUTTONS-1:0] short_press_mask;
	logic                   held_answer;

	button_scoreboard sb = new();
	int unsigned      stall_cycle = 0;

	button_press_hold_classifier_core DUT (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_wdata        (cfg_wdata),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.action           (action),
		.button           (button),
		.pin_high         (pin_high),
		.query_ticks      (query_ticks),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.held_events      (held_events),
		.press_event      (press_event),
		.release_event    (release_event),
		.event_button     (event_button),
		.pressed_mask     (pressed_mask),
		.short_press_mask (short_press_mask),
		.held_answer      (held_answer)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver stall pattern: free, light random, periodic bursts, heavy random
	always @(negedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			stall_cycle <= stall_cycle + 1;
			case ((stall_cycle >> 8) % 4)
				0: out_stall <= 1'b0;
				1: out_stall <= $urandom_range(0, 2) == 0;
				2: out_stall <= (stall_cycle % 16) < 6;
				default: out_stall <= $urandom_range(0, 1) == 1;
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_report({held_events, press_event, release_event, event_button,
				pressed_mask, short_press_mask, held_answer});
	end

	function automatic item_t make_item(int act, int btn, bit lvl, logic [QTICKS_W-1:0] q);
		item_t it;
		it.action      = ACTION_W'(act);
		it.button      = BTN_W'(btn);
		it.pin_high    = lvl;
		it.query_ticks = q;
		return it;
	endfunction

	function automatic item_t rand_item();
		item_t it;
		int    r;
		int    b;
		int    qsel;
		r    = $urandom_range(0, 99);
		b    = $urandom_range(0, NUM_BUTTONS - 1);
		qsel = $urandom_range(0, 9);
		it   = make_item(ACT_TICK, b, 1'($urandom_range(0, 1)), $urandom);
		if (r < 40) begin
			it.action = ACT_TICK;
		end else if (r < 70) begin
			it.action = ACT_PIN;
			if (sb.press_ticks[b] != '0)
				it.pin_high = $urandom_range(0, 3) != 0;
			else
				it.pin_high = $urandom_range(0, 5) == 0;
		end else if (r < 78) begin
			it.action = ACT_PRESS_ACK;
		end else if (r < 85) begin
			it.action = ACT_HOLD_ACK;
		end else if (r < 95) begin
			it.action = ACT_QUERY;
			if (qsel < 6)
				it.query_ticks = sb.press_ticks[b] + $urandom_range(0, 2) - 1;
			else if (qsel < 8)
				it.query_ticks = $urandom_range(0, 15);
		end else begin
			it.action = ACTION_W'($urandom_range(ACT_CODE_MAX, ACT_QUERY + 1));
		end
		return it;
	endfunction

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic send_item(item_t it);
		in_valid    <= 1'b1;
		action      <= it.action;
		button      <= it.button;
		pin_high    <= it.pin_high;
		query_ticks <= it.query_ticks;
		do
			@(posedge clk);
		while (in_stall);
		sb.note_transaction(it);
		@(negedge clk);
	endtask

	task automatic pause_input(int cycles);
		in_valid <= 1'b0;
		repeat (cycles) @(negedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic load_settings(logic [31:0] thresh, logic [31:0] held, logic [31:0] press,
		logic [31:0] rel);
		cfg_we    <= 1'b1;
		cfg_index <= REG_HOLD_THRESH;
		cfg_wdata <= thresh;
		@(negedge clk);
		cfg_index <= REG_HELD_EN;
		cfg_wdata <= held;
		@(negedge clk);
		cfg_index <= REG_PRESS_EN;
		cfg_wdata <= press;
		@(negedge clk);
		cfg_index <= REG_RELEASE_EN;
		cfg_wdata <= rel;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.set_reg(REG_HOLD_THRESH, thresh);
		sb.set_reg(REG_HELD_EN, held);
		sb.set_reg(REG_PRESS_EN, press);
		sb.set_reg(REG_RELEASE_EN, rel);
		@(negedge clk);
	endtask

	initial begin
		#5_000_000;
		$display("button_press_hold_classifier_core test failed");
		$finish;
	end

	initial begin
		logic [31:0] thresh;
		logic [31:0] held;
		logic [31:0] press;
		logic [31:0] rel;
		int          burst_left;
		bit          no_gaps;

		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		cfg_index   = '0;
		cfg_wdata   = '0;
		in_valid    = 1'b0;
		action      = '0;
		button      = '0;
		pin_high    = 1'b0;
		query_ticks = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// reset settings, unused codes, query extremes
		send_item(make_item(ACT_QUERY, 0, 1'b0, '0));
		for (int a = ACT_QUERY + 1; a <= ACT_CODE_MAX; a++)
			send_item(make_item(a, 3, 1'b1, '1));
		send_item(make_item(ACT_PIN, 0, 1'b0, '0));
		send_item(make_item(ACT_TICK, 0, 1'b0, '0));
		send_item(make_item(ACT_QUERY, 0, 1'b0, '1));
		wait_drained();

		// short threshold, all events on
		load_settings(3, 'hF, 'hF, 'hF);
		send_item(make_item(ACT_PIN, 1, 1'b0, '0));
		send_item(make_item(ACT_PIN, 2, 1'b0, '0));
		repeat (3) send_item(make_item(ACT_TICK, 0, 1'b0, '0));
		send_item(make_item(ACT_PIN, 1, 1'b1, '0));
		// press while hold already acknowledged
		send_item(make_item(ACT_HOLD_ACK, 3, 1'b0, '0));
		send_item(make_item(ACT_PIN, 3, 1'b0, '0));
		repeat (3) send_item(make_item(ACT_TICK, 0, 1'b0, '0));
		send_item(make_item(ACT_QUERY, 3, 1'b0, 1));
		send_item(make_item(ACT_PIN, 3, 1'b1, '0));
		send_item(make_item(ACT_PIN, 1, 1'b0, '0));
		send_item(make_item(ACT_PIN, 1, 1'b1, '0));
		send_item(make_item(ACT_PRESS_ACK, 1, 1'b0, '0));
		send_item(make_item(ACT_QUERY, 2, 1'b0, 2));
		wait_drained();

		// zero threshold: every counting tick qualifies
		load_settings(0, 'h5, 'hA, 'h0);
		send_item(make_item(ACT_PIN, 0, 1'b0, '0));
		send_item(make_item(ACT_TICK, 0, 1'b0, '0));
		wait_drained();

		load_settings('1, 'h0, 'h0, 'hF);
		send_item(make_item(ACT_TICK, 0, 1'b0, '0));
		for (int b = 0; b < NUM_BUTTONS; b++)
			send_item(make_item(ACT_PIN, b, 1'b1, '0));
		wait_drained();

		for (int p = 0; p < NUM_PHASES; p++) begin
			case (p)
				0: thresh = 1;
				1: thresh = '1;
				2: thresh = 0;
				3: thresh = $urandom;
				default: thresh = $urandom_range(1, 8);
			endcase
			held  = (p == 4) ? 'h0 : (p == 5) ? 'hF : $urandom_range(0, 15);
			press = (p == 4) ? 'h0 : (p == 5) ? 'hF : $urandom_range(0, 15);
			rel   = (p == 4) ? 'h0 : (p == 5) ? 'hF : $urandom_range(0, 15);
			if (p % 2 == 1) begin
				held  = held | ($urandom & ~32'hF);
				press = press | ($urandom & ~32'hF);
				rel   = rel | ($urandom & ~32'hF);
			end
			load_settings(thresh, held, press, rel);
			no_gaps    = (p % 3 == 0);
			burst_left = $urandom_range(1, 24);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				send_item(rand_item());
				burst_left--;
				if (burst_left == 0) begin
					if (!no_gaps)
						pause_input($urandom_range(1, 6));
					burst_left = $urandom_range(1, 24);
				end
			end
			wait_drained();
		end

		repeat (10) @(negedge clk);
		if (sb.mismatch_count == 0 && sb.pending() == 0)
			$display("button_press_hold_classifier_core test passed");
		else
			$display("button_press_hold_classifier_core test failed");
		$finish;
	end

endmodule

>>> sim.f
src/bphc_pkg.sv
src/bphc_cfg_regs.sv
src/bphc_btn_core.sv
src/button_press_hold_classifier_core.sv
bench/tb_button_press_hold_classifier_core.sv
